// ===== rtl/psra_pkg.sv =====
// Package: types, codes and constants for the paged SPI register access master.
package psra_pkg;

  localparam int unsigned DATA_W         = 64;
  localparam int unsigned MAX_BYTES_DEF  = 8;
  localparam logic [7:0]  POLL_LIMIT_RST = 8'd50;

  localparam logic [1:0] OP_START_RD = 2'd0;
  localparam logic [1:0] OP_START_WR = 2'd1;
  localparam logic [1:0] OP_XFER     = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_POLL_TO = 2'd1;
  localparam logic [1:0] ST_ACK_TO  = 2'd2;

  localparam logic [7:0] SPI_CMD_RD   = 8'h60;
  localparam logic [7:0] SPI_CMD_WR   = 8'h61;
  localparam logic [7:0] SPI_CMD_FRD  = 8'h10;
  localparam logic [7:0] REG_STATUS   = 8'hFE;
  localparam logic [7:0] REG_PAGE     = 8'hFF;
  localparam logic [7:0] SPI_DUMMY    = 8'h00;
  localparam logic [7:0] STS_BUSY     = 8'h80;
  localparam logic [7:0] ACK_MASK     = 8'h03;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_POLL_CMD = 4'd1,
    PH_POLL_REG = 4'd2,
    PH_POLL_DAT = 4'd3,
    PH_PG_CMD   = 4'd4,
    PH_PG_REG   = 4'd5,
    PH_PG_VAL   = 4'd6,
    PH_TO_CMD   = 4'd7,
    PH_TO_REG   = 4'd8,
    PH_TO_VAL   = 4'd9,
    PH_WR_CMD   = 4'd10,
    PH_WR_ADDR  = 4'd11,
    PH_WR_DATA  = 4'd12,
    PH_RD_CMD   = 4'd13,
    PH_RD_ADDR  = 4'd14,
    PH_RD_DATA  = 4'd15
  } phase_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [7:0]        page;
    logic [7:0]        reg_addr;
    logic [3:0]        length;
    logic [DATA_W-1:0] write_data;
    logic [7:0]        miso_byte;
  } in_req_t;

  typedef struct packed {
    logic              is_done;
    logic [7:0]        mosi_byte;
    logic              new_frame;
    logic [1:0]        status;
    logic [DATA_W-1:0] read_data;
  } out_rsp_t;

endpackage

// ===== rtl/psra_seq.sv =====
// Sequencer: transaction state and the next SPI byte or completion for each request.
module psra_seq #(
  parameter int unsigned MAX_BYTES = psra_pkg::MAX_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  psra_pkg::in_req_t  req,
  input  logic [7:0]         poll_limit,
  output logic               fire,
  output psra_pkg::out_rsp_t rsp
);

  localparam int unsigned BUF_W = MAX_BYTES * 8;
  localparam int unsigned IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  psra_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]        tries_r, tries_nxt;
  logic [3:0]        bidx_r, bidx_nxt;
  logic              is_wr_r, is_wr_nxt;
  logic [7:0]        page_r, page_nxt;
  logic [7:0]        addr_r, addr_nxt;
  logic [3:0]        len_r, len_nxt;
  logic [BUF_W-1:0]  wbuf_r;
  logic [BUF_W-1:0]  rbuf_r, rbuf_nxt;

  logic              start;
  logic [7:0]        limit;
  logic [7:0]        tries_dec;
  logic [3:0]        bidx_inc;
  logic [3:0]        len_clamp;
  logic [7:0]        rx;

  assign start     = (req.opcode == psra_pkg::OP_START_RD) ||
                     (req.opcode == psra_pkg::OP_START_WR);
  assign limit     = (poll_limit == 8'd0) ? 8'd1 : poll_limit;
  assign tries_dec = (tries_r != 8'd0) ? tries_r - 8'd1 : 8'd0;
  assign bidx_inc  = bidx_r + 4'd1;
  assign len_clamp = (req.length > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : req.length;
  assign rx        = req.miso_byte;

  always_comb begin
    phase_nxt = phase_r;
    tries_nxt = tries_r;
    bidx_nxt  = bidx_r;
    is_wr_nxt = is_wr_r;
    page_nxt  = page_r;
    addr_nxt  = addr_r;
    len_nxt   = len_r;
    rbuf_nxt  = rbuf_r;
    fire      = 1'b0;
    rsp       = '0;
    if (start) begin
      is_wr_nxt     = (req.opcode == psra_pkg::OP_START_WR);
      page_nxt      = req.page;
      addr_nxt      = req.reg_addr;
      len_nxt       = len_clamp;
      rbuf_nxt      = '0;
      bidx_nxt      = 4'd0;
      tries_nxt     = limit;
      phase_nxt     = psra_pkg::PH_POLL_CMD;
      fire          = 1'b1;
      rsp.mosi_byte = psra_pkg::SPI_CMD_RD;
      rsp.new_frame = 1'b1;
    end else if (req.opcode == psra_pkg::OP_XFER) begin
      fire = 1'b1;
      unique case (phase_r)
        psra_pkg::PH_IDLE: begin
          fire = 1'b0;
        end
        psra_pkg::PH_POLL_CMD: begin
          phase_nxt     = psra_pkg::PH_POLL_REG;
          rsp.mosi_byte = psra_pkg::REG_STATUS;
        end
        psra_pkg::PH_POLL_REG: begin
          phase_nxt     = psra_pkg::PH_POLL_DAT;
          rsp.mosi_byte = psra_pkg::SPI_DUMMY;
        end
        psra_pkg::PH_POLL_DAT: begin
          rsp.new_frame = 1'b1;
          if ((rx & psra_pkg::STS_BUSY) == 8'd0) begin
            phase_nxt     = psra_pkg::PH_PG_CMD;
            rsp.mosi_byte = psra_pkg::SPI_CMD_WR;
          end else begin
            tries_nxt = tries_dec;
            if (tries_dec == 8'd0) begin
              phase_nxt     = psra_pkg::PH_TO_CMD;
              rsp.mosi_byte = psra_pkg::SPI_CMD_WR;
            end else begin
              phase_nxt     = psra_pkg::PH_POLL_CMD;
              rsp.mosi_byte = psra_pkg::SPI_CMD_RD;
            end
          end
        end
        psra_pkg::PH_PG_CMD: begin
          phase_nxt     = psra_pkg::PH_PG_REG;
          rsp.mosi_byte = psra_pkg::REG_PAGE;
        end
        psra_pkg::PH_PG_REG: begin
          phase_nxt     = psra_pkg::PH_PG_VAL;
          rsp.mosi_byte = page_r;
        end
        psra_pkg::PH_PG_VAL: begin
          rsp.new_frame = 1'b1;
          if (is_wr_r) begin
            phase_nxt     = psra_pkg::PH_WR_CMD;
            rsp.mosi_byte = psra_pkg::SPI_CMD_WR;
          end else begin
            tries_nxt     = limit;
            phase_nxt     = psra_pkg::PH_RD_CMD;
            rsp.mosi_byte = psra_pkg::SPI_CMD_FRD;
          end
        end
        psra_pkg::PH_TO_CMD: begin
          phase_nxt     = psra_pkg::PH_TO_REG;
          rsp.mosi_byte = psra_pkg::REG_PAGE;
        end
        psra_pkg::PH_TO_REG: begin
          phase_nxt     = psra_pkg::PH_TO_VAL;
          rsp.mosi_byte = page_r;
        end
        psra_pkg::PH_TO_VAL: begin
          phase_nxt   = psra_pkg::PH_IDLE;
          rsp.is_done = 1'b1;
          rsp.status  = psra_pkg::ST_POLL_TO;
        end
        psra_pkg::PH_WR_CMD: begin
          phase_nxt     = psra_pkg::PH_WR_ADDR;
          rsp.mosi_byte = addr_r;
        end
        psra_pkg::PH_WR_ADDR: begin
          if (len_r == 4'd0) begin
            phase_nxt   = psra_pkg::PH_IDLE;
            rsp.is_done = 1'b1;
          end else begin
            bidx_nxt      = 4'd0;
            phase_nxt     = psra_pkg::PH_WR_DATA;
            rsp.mosi_byte = wbuf_r[7:0];
          end
        end
        psra_pkg::PH_WR_DATA: begin
          bidx_nxt = bidx_inc;
          if (bidx_inc >= len_r) begin
            phase_nxt   = psra_pkg::PH_IDLE;
            rsp.is_done = 1'b1;
          end else begin
            rsp.mosi_byte = wbuf_r[8 * bidx_inc[IDX_W-1:0] +: 8];
          end
        end
        psra_pkg::PH_RD_CMD: begin
          phase_nxt     = psra_pkg::PH_RD_ADDR;
          rsp.mosi_byte = addr_r;
        end
        psra_pkg::PH_RD_ADDR: begin
          if ((rx & psra_pkg::ACK_MASK) != 8'd0) begin
            if (len_r == 4'd0) begin
              phase_nxt   = psra_pkg::PH_IDLE;
              rsp.is_done = 1'b1;
            end else begin
              bidx_nxt      = 4'd0;
              phase_nxt     = psra_pkg::PH_RD_DATA;
              rsp.mosi_byte = psra_pkg::SPI_DUMMY;
            end
          end else begin
            tries_nxt = tries_dec;
            if (tries_dec == 8'd0) begin
              phase_nxt   = psra_pkg::PH_IDLE;
              rsp.is_done = 1'b1;
              rsp.status  = psra_pkg::ST_ACK_TO;
            end else begin
              rsp.mosi_byte = addr_r;
            end
          end
        end
        psra_pkg::PH_RD_DATA: begin
          rbuf_nxt[8 * bidx_r[IDX_W-1:0] +: 8] = rx;
          bidx_nxt = bidx_inc;
          if (bidx_inc >= len_r) begin
            phase_nxt     = psra_pkg::PH_IDLE;
            rsp.is_done   = 1'b1;
            rsp.read_data = psra_pkg::DATA_W'(rbuf_nxt);
          end else begin
            rsp.mosi_byte = psra_pkg::SPI_DUMMY;
          end
        end
        default: begin
          fire = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= psra_pkg::PH_IDLE;
      tries_r <= 8'd0;
      bidx_r  <= 4'd0;
      is_wr_r <= 1'b0;
      page_r  <= 8'd0;
      addr_r  <= 8'd0;
      len_r   <= 4'd0;
      rbuf_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      tries_r <= tries_nxt;
      bidx_r  <= bidx_nxt;
      is_wr_r <= is_wr_nxt;
      page_r  <= page_nxt;
      addr_r  <= addr_nxt;
      len_r   <= len_nxt;
      rbuf_r  <= rbuf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && start) begin
      wbuf_r <= req.write_data[BUF_W-1:0];
    end
  end

endmodule

// ===== rtl/paged_spi_register_access_master.sv =====
// Top level: request register, sequencer, result register and poll limit register.
// Paged SPI register access master. Each request is a start (read or write with page,
// address, length and write bytes) or the report of a finished SPI byte exchange with
// the byte clocked in; each answer is the next byte to shift out (with a flag to pulse
// chip select before it) or the completion with status and read bytes. One request is
// taken every clock cycle unless in_stall is set; a request passes the request register
// and then the result register; the sequencer state updates once per request.
// A full result register that is stalled holds the request register, which then stalls
// the input. cfg_wr_data sets the poll limit (status polls and acknowledge attempts,
// zero acts as one); write it only while no transaction is running.
module paged_spi_register_access_master #(
  parameter int unsigned MAX_BYTES = psra_pkg::MAX_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  psra_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output psra_pkg::out_rsp_t out_rsp,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  logic               req_vld_r, req_vld_nxt;
  psra_pkg::in_req_t  req_r;
  logic               rsp_vld_r, rsp_vld_nxt;
  psra_pkg::out_rsp_t rsp_r;
  logic [7:0]         poll_limit_r;

  logic               rsp_free;
  logic               step;
  logic               accept;
  logic               fire;
  psra_pkg::out_rsp_t seq_rsp;

  assign rsp_free = !rsp_vld_r || !out_stall;
  assign step     = req_vld_r && rsp_free;
  assign in_stall = req_vld_r && !rsp_free;
  assign accept   = in_valid && !in_stall;

  assign req_vld_nxt = accept ? 1'b1 : (step ? 1'b0 : req_vld_r);
  assign rsp_vld_nxt = rsp_free ? (step && fire) : rsp_vld_r;

  psra_seq #(
    .MAX_BYTES (MAX_BYTES)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .req        (req_r),
    .poll_limit (poll_limit_r),
    .fire       (fire),
    .rsp        (seq_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r    <= 1'b0;
      rsp_vld_r    <= 1'b0;
      poll_limit_r <= psra_pkg::POLL_LIMIT_RST;
    end else begin
      req_vld_r <= req_vld_nxt;
      rsp_vld_r <= rsp_vld_nxt;
      if (cfg_wr_en) begin
        poll_limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    if (step && fire) begin
      rsp_r <= seq_rsp;
    end
  end

  assign out_valid = rsp_vld_r;
  assign out_rsp   = rsp_r;

`ifndef SYNTHESIS
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (req_vld_r && rsp_vld_r && out_stall))
    else $error("input stalled while the pipeline can move");

  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.is_done) |-> (!out_rsp.new_frame && out_rsp.mosi_byte == 8'd0))
    else $error("completion carries a byte to send");

  a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rsp.is_done) |->
      (out_rsp.status == psra_pkg::ST_OK && out_rsp.read_data == '0))
    else $error("byte result carries status or read data");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (step && fire) |=> out_valid)
    else $error("produced result was not registered");
`endif

endmodule

// ===== tb/testbench.sv =====
// Testbench: directed table and random SPI transactions on the paged register access master.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import psra_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 240;

  typedef struct packed {
    bit         is_cfg;
    logic [7:0] cfg_val;
    in_req_t    req;
    bit         typed;
    out_rsp_t   ans;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_req_t    in_req = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_rsp_t   out_rsp;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;

  phase_t      sq_phase = PH_IDLE;
  logic [7:0]  sq_tries = '0;
  logic [3:0]  sq_idx = '0;
  logic        sq_write = 1'b0;
  logic [7:0]  sq_page = '0;
  logic [7:0]  sq_addr = '0;
  logic [3:0]  sq_len = '0;
  logic [63:0] sq_wbuf = '0;
  logic [63:0] sq_rbuf = '0;
  logic [7:0]  poll_lim = POLL_LIMIT_RST;

  out_rsp_t pending_answers[$];
  dir_row_t dir_rows[$];
  int       mismatches = 0;
  int       served = 0;
  int       idle_cycles = 0;
  int       tx_burst = 0;
  int       rx_burst = 0;
  bit       hold_off_req = 1'b0;

  paged_spi_register_access_master dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rsp    (out_rsp),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  function automatic bit sequence_answer(input in_req_t r, output out_rsp_t a);
    logic [7:0] lim;
    lim = (poll_lim == 8'd0) ? 8'd1 : poll_lim;
    a = '0;
    if (r.opcode == OP_START_RD || r.opcode == OP_START_WR) begin
      sq_write = (r.opcode == OP_START_WR);
      sq_page  = r.page;
      sq_addr  = r.reg_addr;
      sq_len   = (r.length > MAX_BYTES_DEF) ? 4'(MAX_BYTES_DEF) : r.length;
      sq_wbuf  = r.write_data;
      sq_rbuf  = '0;
      sq_idx   = '0;
      sq_tries = lim;
      sq_phase = PH_POLL_CMD;
      a.mosi_byte = SPI_CMD_RD;
      a.new_frame = 1'b1;
      return 1'b1;
    end
    if (r.opcode != OP_XFER || sq_phase == PH_IDLE) return 1'b0;
    case (sq_phase)
      PH_POLL_CMD: begin
        a.mosi_byte = REG_STATUS;
        sq_phase = PH_POLL_REG;
      end
      PH_POLL_REG: begin
        a.mosi_byte = SPI_DUMMY;
        sq_phase = PH_POLL_DAT;
      end
      PH_POLL_DAT: begin
        a.new_frame = 1'b1;
        if ((r.miso_byte & STS_BUSY) == 8'd0) begin
          a.mosi_byte = SPI_CMD_WR;
          sq_phase = PH_PG_CMD;
        end else begin
          if (sq_tries != 8'd0) sq_tries--;
          if (sq_tries == 8'd0) begin
            a.mosi_byte = SPI_CMD_WR;
            sq_phase = PH_TO_CMD;
          end else begin
            a.mosi_byte = SPI_CMD_RD;
            sq_phase = PH_POLL_CMD;
          end
        end
      end
      PH_PG_CMD: begin
        a.mosi_byte = REG_PAGE;
        sq_phase = PH_PG_REG;
      end
      PH_PG_REG: begin
        a.mosi_byte = sq_page;
        sq_phase = PH_PG_VAL;
      end
      PH_PG_VAL: begin
        a.new_frame = 1'b1;
        if (sq_write) begin
          a.mosi_byte = SPI_CMD_WR;
          sq_phase = PH_WR_CMD;
        end else begin
          sq_tries = lim;
          a.mosi_byte = SPI_CMD_FRD;
          sq_phase = PH_RD_CMD;
        end
      end
      PH_TO_CMD: begin
        a.mosi_byte = REG_PAGE;
        sq_phase = PH_TO_REG;
      end
      PH_TO_REG: begin
        a.mosi_byte = sq_page;
        sq_phase = PH_TO_VAL;
      end
      PH_TO_VAL: begin
        a.is_done = 1'b1;
        a.status = ST_POLL_TO;
      end
      PH_WR_CMD: begin
        a.mosi_byte = sq_addr;
        sq_phase = PH_WR_ADDR;
      end
      PH_WR_ADDR: begin
        if (sq_len == 4'd0) begin
          a.is_done = 1'b1;
        end else begin
          sq_idx = '0;
          a.mosi_byte = sq_wbuf[7:0];
          sq_phase = PH_WR_DATA;
        end
      end
      PH_WR_DATA: begin
        sq_idx++;
        if (sq_idx >= sq_len) a.is_done = 1'b1;
        else a.mosi_byte = sq_wbuf[8*sq_idx[2:0] +: 8];
      end
      PH_RD_CMD: begin
        a.mosi_byte = sq_addr;
        sq_phase = PH_RD_ADDR;
      end
      PH_RD_ADDR: begin
        if ((r.miso_byte & ACK_MASK) != 8'd0) begin
          if (sq_len == 4'd0) begin
            a.is_done = 1'b1;
          end else begin
            sq_idx = '0;
            a.mosi_byte = SPI_DUMMY;
            sq_phase = PH_RD_DATA;
          end
        end else begin
          if (sq_tries != 8'd0) sq_tries--;
          if (sq_tries == 8'd0) begin
            a.is_done = 1'b1;
            a.status = ST_ACK_TO;
          end else begin
            a.mosi_byte = sq_addr;
          end
        end
      end
      PH_RD_DATA: begin
        sq_rbuf[8*sq_idx[2:0] +: 8] = r.miso_byte;
        sq_idx++;
        if (sq_idx >= sq_len) begin
          a.is_done = 1'b1;
          a.read_data = sq_rbuf;
        end else begin
          a.mosi_byte = SPI_DUMMY;
        end
      end
      default: ;
    endcase
    if (a.is_done) sq_phase = PH_IDLE;
    return 1'b1;
  endfunction

  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst = $urandom_range(10, 40);
    return $urandom_range(0, 8);
  endfunction

  function automatic in_req_t mk_req(input logic [1:0] op, input logic [7:0] pg, ad,
                                     input logic [3:0] len, input logic [63:0] wd,
                                     input logic [7:0] miso);
    in_req_t r;
    r.opcode     = op;
    r.page       = pg;
    r.reg_addr   = ad;
    r.length     = len;
    r.write_data = wd;
    r.miso_byte  = miso;
    return r;
  endfunction

  function automatic in_req_t xf(input logic [7:0] miso);
    return mk_req(OP_XFER, 8'h00, 8'h00, 4'd0, 64'd0, miso);
  endfunction

  function automatic dir_row_t free_row(input in_req_t q);
    dir_row_t d;
    d = '0;
    d.req = q;
    return d;
  endfunction

  function automatic dir_row_t byte_row(input in_req_t q, input logic [7:0] mosi,
                                        input logic frame);
    dir_row_t d;
    d = free_row(q);
    d.typed = 1'b1;
    d.ans.mosi_byte = mosi;
    d.ans.new_frame = frame;
    return d;
  endfunction

  function automatic dir_row_t done_row(input in_req_t q, input logic [1:0] st);
    dir_row_t d;
    d = free_row(q);
    d.typed = 1'b1;
    d.ans.is_done = 1'b1;
    d.ans.status = st;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(input logic [7:0] v);
    dir_row_t d;
    d = '0;
    d.is_cfg = 1'b1;
    d.cfg_val = v;
    return d;
  endfunction

  function automatic in_req_t rand_req(input logic [1:0] op);
    in_req_t r;
    r.opcode   = op;
    r.page     = 8'($urandom);
    r.reg_addr = 8'($urandom);
    case ($urandom_range(0, 9))
      0:       r.length = 4'd0;
      1:       r.length = 4'($urandom_range(9, 15));
      default: r.length = 4'($urandom_range(1, 8));
    endcase
    r.write_data = {$urandom, $urandom};
    r.miso_byte  = 8'($urandom);
    return r;
  endfunction

  function automatic logic [7:0] pick_miso();
    logic [7:0] b;
    b = 8'($urandom);
    if (sq_phase == PH_POLL_DAT) begin
      b[7] = ($urandom_range(0, 2) == 0);
    end else if (sq_phase == PH_RD_ADDR) begin
      if ($urandom_range(0, 2) == 0) b[1:0] = 2'b00;
      else if (b[1:0] == 2'b00) b[1:0] = 2'($urandom_range(1, 3));
    end
    return b;
  endfunction

  task automatic offer(input in_req_t r, input bit typed, input out_rsp_t typed_ans);
    int gap;
    out_rsp_t a;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (in_stall);
    if (sequence_answer(r, a)) begin
      pending_answers.push_back(typed ? typed_ans : a);
      served++;
    end
  endtask

  task automatic xfer_step();
    in_req_t r;
    r = rand_req(OP_XFER);
    r.miso_byte = pick_miso();
    offer(r, 1'b0, '0);
  endtask

  task automatic quiesce();
    while (sq_phase != PH_IDLE) xfer_step();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_poll_limit(input logic [7:0] v);
    quiesce();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    poll_lim = v;
  endtask

  task automatic run_transaction();
    offer(rand_req($urandom_range(0, 1) ? OP_START_WR : OP_START_RD), 1'b0, '0);
    while (sq_phase != PH_IDLE) begin
      if ($urandom_range(0, 99) == 0) return;
      if ($urandom_range(0, 29) == 0) offer(rand_req(OP_UNUSED), 1'b0, '0);
      xfer_step();
    end
    if ($urandom_range(0, 9) == 0) offer(rand_req(OP_XFER), 1'b0, '0);
  endtask

  task automatic flag(input string field, input logic [63:0] want_v, got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t %s expected %h got %h", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        $display("%0t result expected none got %h", $time, out_rsp);
      end else begin
        want = pending_answers.pop_front();
        flag("is_done", want.is_done, out_rsp.is_done);
        flag("mosi_byte", want.mosi_byte, out_rsp.mosi_byte);
        flag("new_frame", want.new_frame, out_rsp.new_frame);
        flag("status", want.status, out_rsp.status);
        flag("read_data", want.read_data, out_rsp.read_data);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL paged_spi_register_access_master");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        n = HOLD_CYCLES;
      end else begin
        n = draw_gap(rx_burst);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int p;
    int phase_base;
    logic [7:0] lim;
    dir_rows.push_back(free_row(xf(8'hFF)));
    dir_rows.push_back(free_row(mk_req(OP_UNUSED, 8'hFF, 8'hFF, 4'hF, '1, 8'hFF)));
    dir_rows.push_back(byte_row(mk_req(OP_START_RD, 8'h00, 8'h00, 4'd0, '0, 8'h00),
                                SPI_CMD_RD, 1'b1));
    dir_rows.push_back(byte_row(mk_req(OP_START_WR, 8'hFF, 8'hFF, 4'd1, '1, 8'h00),
                                SPI_CMD_RD, 1'b1));
    dir_rows.push_back(byte_row(xf(8'hFF), REG_STATUS, 1'b0));
    dir_rows.push_back(byte_row(xf(8'h00), SPI_DUMMY, 1'b0));
    dir_rows.push_back(byte_row(xf(8'h7F), SPI_CMD_WR, 1'b1));
    dir_rows.push_back(byte_row(xf(8'h00), REG_PAGE, 1'b0));
    dir_rows.push_back(byte_row(xf(8'h00), 8'hFF, 1'b0));
    dir_rows.push_back(byte_row(xf(8'h00), SPI_CMD_WR, 1'b1));
    dir_rows.push_back(byte_row(xf(8'h00), 8'hFF, 1'b0));
    dir_rows.push_back(byte_row(xf(8'h00), 8'hFF, 1'b0));
    dir_rows.push_back(done_row(xf(8'h00), ST_OK));
    dir_rows.push_back(cfg_row(8'd0));
    dir_rows.push_back(byte_row(mk_req(OP_START_RD, 8'hA5, 8'h5A, 4'hF, '0, 8'h00),
                                SPI_CMD_RD, 1'b1));
    dir_rows.push_back(byte_row(xf(8'h00), REG_STATUS, 1'b0));
    dir_rows.push_back(byte_row(xf(8'h00), SPI_DUMMY, 1'b0));
    dir_rows.push_back(byte_row(xf(8'h80), SPI_CMD_WR, 1'b1));
    dir_rows.push_back(byte_row(xf(8'h00), REG_PAGE, 1'b0));
    dir_rows.push_back(byte_row(xf(8'h00), 8'hA5, 1'b0));
    dir_rows.push_back(done_row(xf(8'h00), ST_POLL_TO));
    dir_rows.push_back(byte_row(mk_req(OP_START_RD, 8'h00, 8'hC3, 4'd8, '0, 8'h00),
                                SPI_CMD_RD, 1'b1));
    dir_rows.push_back(byte_row(xf(8'h00), REG_STATUS, 1'b0));
    dir_rows.push_back(byte_row(xf(8'h00), SPI_DUMMY, 1'b0));
    dir_rows.push_back(byte_row(xf(8'h00), SPI_CMD_WR, 1'b1));
    dir_rows.push_back(byte_row(xf(8'h00), REG_PAGE, 1'b0));
    dir_rows.push_back(byte_row(xf(8'h00), 8'h00, 1'b0));
    dir_rows.push_back(byte_row(xf(8'h00), SPI_CMD_FRD, 1'b1));
    dir_rows.push_back(byte_row(xf(8'h00), 8'hC3, 1'b0));
    dir_rows.push_back(done_row(xf(8'hFC), ST_ACK_TO));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) set_poll_limit(dir_rows[i].cfg_val);
      else offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].ans);
    end

    for (p = 0; p < 8; p++) begin
      case (p)
        0:       lim = 8'd1;
        1:       lim = 8'd255;
        2:       lim = 8'd2;
        3:       lim = 8'd0;
        4:       lim = 8'd3;
        5:       lim = POLL_LIMIT_RST;
        6:       lim = 8'($urandom_range(1, 6));
        default: lim = 8'($urandom_range(1, 255));
      endcase
      set_poll_limit(lim);
      phase_base = served;
      // hold the result side long enough to back up the request side
      if (p == 1) hold_off_req = 1'b1;
      while (served - phase_base < PHASE_ITEMS) run_transaction();
    end

    quiesce();
    if (mismatches == 0) $display("PASS paged_spi_register_access_master");
    else $display("FAIL paged_spi_register_access_master");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/psra_pkg.sv
rtl/psra_seq.sv
rtl/paged_spi_register_access_master.sv
tb/testbench.sv
